[sv/cosr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_pkg
// Shared types and constants of the column occlusion span renderer.
// ----------------------------------------------------------------------------
package cosr_pkg;

   localparam int COLUMNS_DEFAULT = 2048;
   localparam int ADDR_MAX_W      = 12;      // enough for 4096 columns
   localparam int ROW_W           = 12;
   localparam int COL_W           = 11;
   localparam int COLOR_W         = 32;
   localparam int HGT_W           = 8;
   localparam int INV_W           = 23;
   localparam int HOR_W           = 24;
   localparam int PROD_W          = 33;      // 9b signed x 24b signed

   // configuration register indexes
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_HORIZON_ROW   = 2'd1;
   localparam logic [1:0] CSR_EYE_LEVEL     = 2'd2;

   localparam logic [ROW_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
   localparam logic [HOR_W-1:0] HORIZON_ROW_RST   = 24'd786432;
   localparam logic [HGT_W-1:0] EYE_LEVEL_RST     = 8'd50;

   // request kinds on req_tuser
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [ROW_W-1:0]   span_end;
      logic [ROW_W-1:0]   span_begin;
      logic [COL_W-1:0]   column;
   } span_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_MAX_W-1:0] addr;
      logic [ROW_W-1:0]      data;
   } top_wr_type;

endpackage

[sv/column_occlusion_span_renderer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_occlusion_span_renderer_top
// Per-column occlusion test and span generation for terrain rendering.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one request per terrain sample (req_tuser = 0) or a clear
//    of all column tops (req_tuser = 1). Samples with column >= COLUMNS are
//    dropped without a span.
//  - rsp channel: zero or one span per sample, in request order.
//  - csr channel: always ready; write only while the block is idle.
//  - Throughput: one request per clock while req_tready is high. Spans
//    reach rsp after multiply, clip and occlusion compare + queue.
//  - The column top memory is read at accept and written back from stage 2;
//    reads that overlap a pending write to the same column are forwarded.
//  - A clear waits for in-flight samples to retire, then sweeps the memory
//    one entry per cycle, with req_tready low until the sweep ends.
//  - After reset the same sweep runs, with req_tready low until it ends.
//  - rsp stalls are absorbed by a 4-entry queue; req_tready also drops when
//    the queue plus in-flight samples could overflow it.
// ----------------------------------------------------------------------------
module column_occlusion_span_renderer_top #(
   parameter int COLUMNS = cosr_pkg::COLUMNS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: column[10:0], terrain_height[18:11], texel_color[50:19],
   //            inv_depth[73:51], zero pad[79:74]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   // req_tuser: cmd[0]
   input  logic [0:0]   req_tuser,
   // rsp_tdata: span_column[10:0], span_begin[22:11], span_end[34:23],
   //            span_color[66:35], zero pad[71:67]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,
   // configuration write
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_data
);

   localparam logic [12:0] ColLimit = 13'(COLUMNS);

   // configuration registers
   logic [cosr_pkg::ROW_W-1:0] screen_height_ff;
   logic [cosr_pkg::HOR_W-1:0] horizon_row_ff;
   logic [cosr_pkg::HGT_W-1:0] eye_level_ff;

   // request fields
   logic [cosr_pkg::COL_W-1:0]   req_column;
   logic [cosr_pkg::HGT_W-1:0]   req_height;
   logic [cosr_pkg::COLOR_W-1:0] req_color;
   logic [cosr_pkg::INV_W-1:0]   req_inv;
   logic                         req_acc;
   logic                         req_clear;

   // pipeline
   logic                         s1_v_ff, s1_v_in;
   logic [cosr_pkg::COL_W-1:0]   s1_col_ff;
   logic [cosr_pkg::COLOR_W-1:0] s1_color_ff;
   logic                         s2_v_ff;
   logic [cosr_pkg::COL_W-1:0]   s2_col_ff;
   logic [cosr_pkg::COLOR_W-1:0] s2_color_ff;
   logic [cosr_pkg::ROW_W-1:0]   s2_top_ff, s2_top_in;
   logic [cosr_pkg::ROW_W-1:0]   s2_row;
   logic                         s2_push;

   // forwarding of the write committed at the read edge
   logic                         byp_v_ff;
   logic [cosr_pkg::COL_W-1:0]   byp_col_ff;
   logic [cosr_pkg::ROW_W-1:0]   byp_row_ff;

   logic [cosr_pkg::ROW_W-1:0]   mem_rd;
   cosr_pkg::top_wr_type         top_wr;
   logic                         store_busy;
   logic                         pipe_idle;

   cosr_pkg::span_type           span_push;
   cosr_pkg::span_type           span_head;
   logic                         q_pop;
   logic [cosr_pkg::QCNT_W-1:0]  q_count;
   logic [cosr_pkg::QCNT_W-1:0]  q_committed;

   assign req_column = req_tdata[10:0];
   assign req_height = req_tdata[18:11];
   assign req_color  = req_tdata[50:19];
   assign req_inv    = req_tdata[73:51];

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_height_ff <= cosr_pkg::SCREEN_HEIGHT_RST;
         horizon_row_ff   <= cosr_pkg::HORIZON_ROW_RST;
         eye_level_ff     <= cosr_pkg::EYE_LEVEL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cosr_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[11:0];
            cosr_pkg::CSR_HORIZON_ROW:   horizon_row_ff   <= csr_data;
            cosr_pkg::CSR_EYE_LEVEL:     eye_level_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- request acceptance ----------------
   // queue slots already promised to entries and in-flight samples
   assign q_committed = q_count + cosr_pkg::QCNT_W'(s1_v_ff) + cosr_pkg::QCNT_W'(s2_v_ff);
   assign req_tready  = !store_busy && (q_committed < cosr_pkg::QCNT_W'(cosr_pkg::QUEUE_DEPTH));
   assign req_acc     = req_tvalid && req_tready;
   assign req_clear   = req_acc && (req_tuser[0] == cosr_pkg::CMD_CLEAR);
   assign s1_v_in     = req_acc && (req_tuser[0] == cosr_pkg::CMD_SAMPLE)
                        && ({2'b00, req_column} < ColLimit);
   assign pipe_idle   = !s1_v_ff && !s2_v_ff;

   // ---------------- row computation ----------------
   cosr_row_calc u_row_calc (
      .clock          (clock),
      .eye_level      (eye_level_ff),
      .horizon_row    (horizon_row_ff),
      .screen_height  (screen_height_ff),
      .terrain_height (req_height),
      .inv_depth      (req_inv),
      .row            (s2_row)
   );

   // ---------------- column top memory ----------------
   cosr_top_store #(
      .COLUMNS (COLUMNS)
   ) u_top_store (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (cosr_pkg::ADDR_MAX_W'(req_column)),
      .rd_data   (mem_rd),
      .wr        (top_wr),
      .clear_req (req_clear),
      .pipe_idle (pipe_idle),
      .busy      (store_busy)
   );

   // stage 1: pick the newest top for the column
   always_comb begin
      if (s2_push && (s2_col_ff == s1_col_ff)) begin
         s2_top_in = s2_row;
      end else if (byp_v_ff && (byp_col_ff == s1_col_ff)) begin
         s2_top_in = byp_row_ff;
      end else begin
         s2_top_in = mem_rd;
      end
   end

   // stage 2: occlusion test, write back, push span
   assign s2_push     = s2_v_ff && (s2_row > s2_top_ff);
   assign top_wr.en   = s2_push;
   assign top_wr.addr = cosr_pkg::ADDR_MAX_W'(s2_col_ff);
   assign top_wr.data = s2_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         byp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s1_v_ff;
         byp_v_ff <= s2_push;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff   <= req_column;
      s1_color_ff <= req_color;
      s2_col_ff   <= s1_col_ff;
      s2_color_ff <= s1_color_ff;
      s2_top_ff   <= s2_top_in;
      byp_col_ff  <= s2_col_ff;
      byp_row_ff  <= s2_row;
   end

   // ---------------- output queue ----------------
   assign span_push.color      = s2_color_ff;
   assign span_push.span_end   = s2_row;
   assign span_push.span_begin = s2_top_ff;
   assign span_push.column     = s2_col_ff;
   assign q_pop                = rsp_tvalid && rsp_tready;

   cosr_span_queue u_span_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_push),
      .push_data (span_push),
      .pop       (q_pop),
      .head      (span_head),
      .not_empty (rsp_tvalid),
      .count     (q_count)
   );

   assign rsp_tdata = {5'd0, span_head.color, span_head.span_end,
                       span_head.span_begin, span_head.column};

   // ---------------- assertions ----------------
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s2_push |-> (q_count < cosr_pkg::QCNT_W'(cosr_pkg::QUEUE_DEPTH)) || q_pop)
      else $error("span queue overflow");

   a_span_clipped: assert property (@(posedge clock) disable iff (reset)
      s2_push |-> (s2_row <= screen_height_ff))
      else $error("span end beyond screen height");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      req_clear |=> !req_tready)
      else $error("request accepted right after clear");

   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (store_busy && pipe_idle) |=> !s2_v_ff)
      else $error("sample in flight during clearing sweep");

endmodule

[sv/cosr_row_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_row_calc
// Two-stage row computation: multiply, then subtract from horizon and clip.
// ----------------------------------------------------------------------------
module cosr_row_calc (
   input  logic                            clock,
   input  logic [cosr_pkg::HGT_W-1:0]      eye_level,
   input  logic [cosr_pkg::HOR_W-1:0]      horizon_row,
   input  logic [cosr_pkg::ROW_W-1:0]      screen_height,
   input  logic [cosr_pkg::HGT_W-1:0]      terrain_height,
   input  logic [cosr_pkg::INV_W-1:0]      inv_depth,
   output logic [cosr_pkg::ROW_W-1:0]      row
);

   logic signed [cosr_pkg::HGT_W:0]      diff_s;
   logic signed [cosr_pkg::INV_W:0]      inv_s;
   logic signed [cosr_pkg::PROD_W-1:0]   prod_in;
   logic signed [cosr_pkg::PROD_W-1:0]   prod_ff;
   logic signed [cosr_pkg::PROD_W:0]     val;
   logic [cosr_pkg::PROD_W-13:0]         quot;
   logic [cosr_pkg::ROW_W-1:0]           row_in;
   logic [cosr_pkg::ROW_W-1:0]           row_ff;

   assign diff_s  = $signed({1'b0, eye_level}) - $signed({1'b0, terrain_height});
   assign inv_s   = $signed({1'b0, inv_depth});
   assign prod_in = diff_s * inv_s;

   // horizon minus product, Q.12; floor is the arithmetic shift
   assign val  = $signed({10'd0, horizon_row}) - $signed({prod_ff[cosr_pkg::PROD_W-1], prod_ff});
   assign quot = val[cosr_pkg::PROD_W-1:12];

   always_comb begin
      if (val[cosr_pkg::PROD_W]) begin
         row_in = '0;
      end else if (quot > {9'd0, screen_height}) begin
         row_in = screen_height;
      end else begin
         row_in = quot[cosr_pkg::ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      row_ff  <= row_in;
   end

   assign row = row_ff;

endmodule

[sv/cosr_top_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_top_store
// Column top memory with registered read and a clearing sweep.
// ----------------------------------------------------------------------------
module cosr_top_store #(
   parameter int COLUMNS = cosr_pkg::COLUMNS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cosr_pkg::ADDR_MAX_W-1:0]     rd_addr,
   output logic [cosr_pkg::ROW_W-1:0]          rd_data,
   input  cosr_pkg::top_wr_type                wr,
   input  logic                                clear_req,
   input  logic                                pipe_idle,
   output logic                                busy
);

   localparam int AW = $clog2(COLUMNS);
   localparam logic [AW-1:0] LastAddr = AW'(COLUMNS - 1);

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_WAIT  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [cosr_pkg::ROW_W-1:0] mem [COLUMNS];
   logic [cosr_pkg::ROW_W-1:0] rd_data_ff;
   logic [1:0]                 state_ff, state_in;
   logic [AW-1:0]              cnt_ff, cnt_in;
   logic                       wen;
   logic [AW-1:0]              waddr;
   logic [cosr_pkg::ROW_W-1:0] wdata;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_RUN: begin
            if (clear_req) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            cnt_in = '0;
            if (pipe_idle) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LastAddr) state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      if (state_ff == ST_SWEEP) begin
         wen   = 1'b1;
         waddr = cnt_ff;
         wdata = '0;
      end else begin
         wen   = wr.en;
         waddr = wr.addr[AW-1:0];
         wdata = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;
   assign busy    = (state_ff != ST_RUN);

endmodule

[sv/cosr_span_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosr_span_queue
// Small output queue for spans; decouples the pipeline from rsp stalls.
// ----------------------------------------------------------------------------
module cosr_span_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  cosr_pkg::span_type                push_data,
   input  logic                              pop,
   output cosr_pkg::span_type                head,
   output logic                              not_empty,
   output logic [cosr_pkg::QCNT_W-1:0]       count
);

   cosr_pkg::span_type               entry_ff [cosr_pkg::QUEUE_DEPTH];
   logic [cosr_pkg::QPTR_W-1:0]      wp_ff, rp_ff;
   logic [cosr_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + cosr_pkg::QCNT_W'(1);
      if (!push && pop) cnt_in = cnt_ff - cosr_pkg::QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + cosr_pkg::QPTR_W'(1);
         if (pop)  rp_ff <= rp_ff + cosr_pkg::QPTR_W'(1);
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wp_ff] <= push_data;
   end

   assign head      = entry_ff[rp_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

endmodule
